@@ rtl/rjtq_pkg.sv @@
// Shared types and constants for the repeating job timer queue.
// Used by rjtq_cell, repeating_job_timer_queue and tb_top; depends on nothing.
package rjtq_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int TIME_W      = 48;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int NFIRE_W     = $clog2(MAX_RESULTS + 1);

  localparam logic [15:0] UNIT_RESET = 16'd1000;

  localparam logic [1:0] KIND_ONCE      = 2'd0;
  localparam logic [1:0] KIND_COUNTED   = 2'd1;
  localparam logic [1:0] KIND_PERMANENT = 2'd2;

  localparam logic [1:0] RES_ACCEPTED   = 2'd0;
  localparam logic [1:0] RES_ZERO_COUNT = 2'd1;
  localparam logic [1:0] RES_FULL       = 2'd2;
  localparam logic [1:0] RES_FIRED      = 2'd3;

  localparam logic ACT_REGISTER = 1'b0;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_RESCHED,
    OP_COUNT,
    OP_CLEAR
  } slot_op_t;

  // broadcast update to one slot
  typedef struct packed {
    slot_op_t            op;
    logic [IDX_W-1:0]    idx;
    logic [7:0]          tag;
    logic [1:0]          kind;
    logic [15:0]         ivl;
    logic [15:0]         rem;
    logic [TIME_W-1:0]   dl;
  } slot_cmd_t;

  // earliest due job seen so far along the chain
  typedef struct packed {
    logic                found;
    logic [TIME_W-1:0]   dl;
    logic [IDX_W-1:0]    idx;
    logic [7:0]          tag;
    logic [1:0]          kind;
    logic [15:0]         ivl;
    logic [15:0]         rem;
  } best_t;

endpackage

@@ rtl/repeating_job_timer_queue.sv @@
// Top level of the repeating job timer queue: control sequencer, time base,
// output register and the chain of rjtq_cell slots. Depends on rjtq_pkg.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_stall, action, job_tag, job_kind, | into block
//          | interval, repeat_count                         |
//  out     | out_valid, out_stall, result_kind, fired_tag,  | out of block
//          | last_of_run                                    |
//  cfg     | cfg_write, cfg_data (ticks_per_interval_unit)  | into block
//
// Register word: a rejected word goes straight to S_REG_DONE; an accepted one
//   first passes S_MUL and S_WRITE; both then wait for the output register.
// Tick word: one chain pass per fired job plus one final pass, each fire
//   followed by S_MUL and S_WRITE; a tick that reaches MAX_RESULTS fires ends
//   without the final pass. A quiet tick is a single chain pass.
// rst is synchronous; it empties the table, zeroes time and loads unit 1000.
// in_stall is high while a word is being worked; out_stall holds the sequencer
//   only when a new result word is ready and the output register is full.
module repeating_job_timer_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  job_tag,
  input  logic [1:0]  job_kind,
  input  logic [15:0] interval,
  input  logic [15:0] repeat_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  fired_tag,
  output logic        last_of_run,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data
);
  import rjtq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_WRITE,
    S_EMIT_LAST,
    S_REG_DONE
  } state_t;

  state_t               state;
  logic [15:0]          unit;
  logic [TIME_W-1:0]    now;
  logic [CNT_W-1:0]     cnt;
  logic [NFIRE_W-1:0]   nfire;
  logic                 pend;
  logic [7:0]           pend_tag;
  logic                 is_new;
  logic [IDX_W-1:0]     sel_idx;
  logic [7:0]           sel_tag;
  logic [1:0]           sel_kind;
  logic [15:0]          sel_ivl;
  logic [15:0]          sel_rem;
  logic [31:0]          prod;
  logic [1:0]           res_code;

  logic                 out_free;
  logic                 in_acc;
  logic                 scan_done;
  logic [TABLE_DEPTH-1:0] busy;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  slot_cmd_t            cmd;
  best_t                chain [TABLE_DEPTH+1];
  best_t                best;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign scan_done = (state == S_SCAN) && (cnt == CNT_W'(TABLE_DEPTH));
  assign best      = chain[TABLE_DEPTH];
  assign chain[0]  = '0;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // slot update issued in the write cycle
  always_comb begin
    cmd      = '{op: OP_NONE, idx: sel_idx, tag: sel_tag, kind: sel_kind,
                 ivl: sel_ivl, rem: sel_rem, dl: now + {16'd0, prod}};
    if (state == S_WRITE) begin
      if (is_new) begin
        cmd.op = OP_LOAD;
      end else if (sel_kind == KIND_PERMANENT) begin
        cmd.op = OP_RESCHED;
      end else if (sel_kind == KIND_COUNTED && sel_rem != 16'd0) begin
        cmd.op = OP_COUNT;
      end else begin
        cmd.op = OP_CLEAR;
      end
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_slot
    rjtq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .slot_idx (IDX_W'(g)),
      .now      (now),
      .cmd      (cmd),
      .best_in  (chain[g]),
      .best_out (chain[g+1]),
      .busy     (busy[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      unit      <= UNIT_RESET;
      now       <= '0;
      cnt       <= '0;
      nfire     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unit <= cfg_data;
      end
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            sel_tag  <= job_tag;
            sel_kind <= job_kind;
            sel_ivl  <= interval;
            sel_rem  <= repeat_count;
            sel_idx  <= free_idx;
            is_new   <= 1'b1;
            if (action == ACT_REGISTER) begin
              if (job_kind == KIND_COUNTED && repeat_count == 16'd0) begin
                res_code <= RES_ZERO_COUNT;
                state    <= S_REG_DONE;
              end else if (!free_found) begin
                res_code <= RES_FULL;
                state    <= S_REG_DONE;
              end else begin
                res_code <= RES_ACCEPTED;
                state    <= S_MUL;
              end
            end else begin
              now   <= now + TIME_W'(1);
              nfire <= '0;
              cnt   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (!scan_done) begin
            cnt <= cnt + CNT_W'(1);
          end else if (!best.found) begin
            state <= pend ? S_EMIT_LAST : S_IDLE;
          end else if (!pend || out_free) begin
            if (pend) begin
              out_valid   <= 1'b1;
              result_kind <= RES_FIRED;
              fired_tag   <= pend_tag;
              last_of_run <= 1'b0;
            end
            pend     <= 1'b1;
            pend_tag <= best.tag;
            nfire    <= nfire + NFIRE_W'(1);
            sel_idx  <= best.idx;
            sel_tag  <= best.tag;
            sel_kind <= best.kind;
            sel_ivl  <= best.ivl;
            sel_rem  <= best.rem;
            is_new   <= 1'b0;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 32'(sel_ivl) * 32'(unit);
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (is_new) begin
            state <= S_REG_DONE;
          end else if (nfire == NFIRE_W'(MAX_RESULTS)) begin
            state <= S_EMIT_LAST;
          end else begin
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_EMIT_LAST: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            result_kind <= RES_FIRED;
            fired_tag   <= pend_tag;
            last_of_run <= 1'b1;
            pend        <= 1'b0;
            state       <= S_IDLE;
          end
        end
        S_REG_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            result_kind <= res_code;
            fired_tag   <= 8'd0;
            last_of_run <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_nfire_bound: assert property (@(posedge clk) disable iff (rst)
    nfire <= NFIRE_W'(MAX_RESULTS))
    else $error("fire count past limit");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend)
    else $error("pending fire left behind");

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    in_acc && action != ACT_REGISTER |=> now == $past(now) + TIME_W'(1))
    else $error("time did not advance on tick");

  a_best_due: assert property (@(posedge clk) disable iff (rst)
    scan_done && best.found |-> best.dl < now)
    else $error("chain picked a job that is not due");
`endif

endmodule

@@ rtl/rjtq_cell.sv @@
// One job slot of the timer table plus one stage of the min-deadline chain.
// Depends on rjtq_pkg.
module rjtq_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rjtq_pkg::IDX_W-1:0]  slot_idx,
  input  logic [rjtq_pkg::TIME_W-1:0] now,
  input  rjtq_pkg::slot_cmd_t       cmd,
  input  rjtq_pkg::best_t           best_in,
  output rjtq_pkg::best_t           best_out,
  output logic                      busy
);
  import rjtq_pkg::*;

  logic              valid;
  logic [TIME_W-1:0] deadline;
  logic [7:0]        tag;
  logic [1:0]        kind;
  logic [15:0]       ivl;
  logic [15:0]       rem;
  logic              take;
  logic              hit;

  assign busy = valid;
  assign hit  = (cmd.idx == slot_idx);
  // strict compare keeps the lower slot on equal deadlines
  assign take = valid && (deadline < now) && (!best_in.found || deadline < best_in.dl);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid          <= 1'b0;
      best_out.found <= 1'b0;
    end else begin
      if (take) begin
        best_out <= '{found: 1'b1, dl: deadline, idx: slot_idx, tag: tag,
                      kind: kind, ivl: ivl, rem: rem};
      end else begin
        best_out <= best_in;
      end
      if (hit) begin
        unique case (cmd.op)
          OP_LOAD: begin
            valid    <= 1'b1;
            tag      <= cmd.tag;
            kind     <= cmd.kind;
            ivl      <= cmd.ivl;
            rem      <= cmd.rem;
            deadline <= cmd.dl;
          end
          OP_RESCHED: deadline <= cmd.dl;
          OP_COUNT: begin
            rem      <= rem - 16'd1;
            deadline <= cmd.dl;
          end
          OP_CLEAR: valid <= 1'b0;
          default: ;
        endcase
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking bench for repeating_job_timer_queue: directed table, then random words.
// Depends on rjtq_pkg and the RTL top level; all results checked by a built-in timer model.
module tb_top;
  import rjtq_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        action;
  logic [7:0]  job_tag;
  logic [1:0]  job_kind;
  logic [15:0] interval;
  logic [15:0] repeat_count;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  result_kind;
  logic [7:0]  fired_tag;
  logic        last_of_run;
  logic        cfg_write;
  logic [15:0] cfg_data;

  repeating_job_timer_queue u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .job_tag(job_tag), .job_kind(job_kind),
    .interval(interval), .repeat_count(repeat_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_kind(result_kind), .fired_tag(fired_tag), .last_of_run(last_of_run),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic       act;
    logic [7:0] tag;
    logic [1:0] kind;
    logic [15:0] ivl;
    logic [15:0] cnt;
  } job_word_t;

  typedef struct packed {
    logic [1:0] rkind;
    logic [7:0] tag;
    logic       last;
  } timer_result_t;

  // directed row: the word, plus a typed-in result where obvious
  typedef struct packed {
    job_word_t     w;
    logic          has_fixed;
    timer_result_t fixed;
  } stim_row_t;

  // ---- timer model state ----
  logic [15:0]       m_unit;
  logic [TIME_W-1:0] m_now;
  logic              m_valid [TABLE_DEPTH];
  logic [TIME_W-1:0] m_dl    [TABLE_DEPTH];
  logic [7:0]        m_tag   [TABLE_DEPTH];
  logic [1:0]        m_kind  [TABLE_DEPTH];
  logic [15:0]       m_ivl   [TABLE_DEPTH];
  logic [15:0]       m_rem   [TABLE_DEPTH];

  timer_result_t pending_results[$];
  int  errors;
  bit  idle_on;   // random idling enabled

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // hard stop: worst case is far below this
  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [TIME_W-1:0] due_at(logic [15:0] ivl);
    return m_now + TIME_W'(ivl) * TIME_W'(m_unit);
  endfunction

  task automatic model_reset();
    m_unit = UNIT_RESET;
    m_now  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) m_valid[i] = 1'b0;
  endtask

  // works out every result a word causes and queues them
  task automatic predict_timer(job_word_t w);
    int free_slot;
    int best;
    int n;
    int first;
    free_slot = -1;
    n = 0;
    if (w.act == ACT_REGISTER) begin
      if (w.kind == KIND_COUNTED && w.cnt == 0) begin
        pending_results.push_back('{RES_ZERO_COUNT, 8'd0, 1'b1});
        return;
      end
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) if (!m_valid[i]) free_slot = i;
      if (free_slot < 0) begin
        pending_results.push_back('{RES_FULL, 8'd0, 1'b1});
        return;
      end
      m_valid[free_slot] = 1'b1;
      m_tag[free_slot]   = w.tag;
      m_kind[free_slot]  = w.kind;
      m_ivl[free_slot]   = w.ivl;
      m_rem[free_slot]   = w.cnt;
      m_dl[free_slot]    = due_at(w.ivl);
      pending_results.push_back('{RES_ACCEPTED, 8'd0, 1'b1});
      return;
    end
    m_now = m_now + TIME_W'(1);
    first = pending_results.size();
    while (n < MAX_RESULTS) begin
      best = -1;
      for (int i = 0; i < TABLE_DEPTH; i++)
        if (m_valid[i] && m_dl[i] < m_now && (best < 0 || m_dl[i] < m_dl[best])) best = i;
      if (best < 0) break;
      pending_results.push_back('{RES_FIRED, m_tag[best], 1'b0});
      n++;
      if (m_kind[best] == KIND_PERMANENT) begin
        m_dl[best] = due_at(m_ivl[best]);
      end else if (m_kind[best] == KIND_COUNTED && m_rem[best] != 16'd0) begin
        m_rem[best] = m_rem[best] - 16'd1;
        m_dl[best]  = due_at(m_ivl[best]);
      end else begin
        m_valid[best] = 1'b0;
      end
    end
    if (n > 0) pending_results[first + n - 1].last = 1'b1;
  endtask

  // ---- result checker ----
  always @(posedge clk) begin
    timer_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word exp none act kind=%0d tag=%0d last=%0d",
                 $time, result_kind, fired_tag, last_of_run);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_kind !== exp_r.rkind) begin
          $display("%0t: result_kind exp %0d act %0d", $time, exp_r.rkind, result_kind);
          errors++;
        end
        if (fired_tag !== exp_r.tag) begin
          $display("%0t: fired_tag exp %0d act %0d", $time, exp_r.tag, fired_tag);
          errors++;
        end
        if (last_of_run !== exp_r.last) begin
          $display("%0t: last_of_run exp %0d act %0d", $time, exp_r.last, last_of_run);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure, stalling at random with 13 percent probability while idling is enabled
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= idle_on && ($urandom_range(99) < 13);
  end

  // hand one word over and wait for acceptance; valid stays up into the next word
  task automatic send_word(job_word_t w);
    while (idle_on && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= w.act;
    job_tag      <= w.tag;
    job_kind     <= w.kind;
    interval     <= w.ivl;
    repeat_count <= w.cnt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timer(w);
  endtask

  task automatic drain_wait();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a quiet tick gives no result, so let one full scan finish
    repeat (4 * TABLE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_unit(logic [15:0] u);
    drain_wait();
    cfg_data  <= u;
    cfg_write <= 1'b1;
    @(posedge clk);
    cfg_write <= 1'b0;
    m_unit = u;
  endtask

  function automatic job_word_t make_job(logic [7:0] tag, logic [1:0] kind,
                                         logic [15:0] ivl, logic [15:0] cnt);
    return '{ACT_REGISTER, tag, kind, ivl, cnt};
  endfunction

  function automatic job_word_t tick_word();
    job_word_t w;
    w = '{1'b1, 8'($urandom), 2'($urandom), 16'($urandom), 16'($urandom)};
    return w;
  endfunction

  localparam timer_result_t R_OK   = '{RES_ACCEPTED, 8'd0, 1'b1};
  localparam timer_result_t R_ZERO = '{RES_ZERO_COUNT, 8'd0, 1'b1};
  localparam timer_result_t R_FULL = '{RES_FULL, 8'd0, 1'b1};
  localparam timer_result_t R_NONE = '0;

  stim_row_t directed_rows[$];
  int        mode;

  initial begin
    timer_result_t got_r;
    job_word_t     w;
    errors       = 0;
    idle_on      = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = 1'b0;
    job_tag      = '0;
    job_kind     = '0;
    interval     = '0;
    repeat_count = '0;
    cfg_write    = 1'b0;
    cfg_data     = '0;
    model_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs at reset unit 1000, then unit 0 for fast fires
    // zero-count rejection, all kinds incl. kind three, extremes of fields
    directed_rows.push_back('{make_job(8'hFF, KIND_COUNTED, 16'hFFFF, 16'd0), 1'b1, R_ZERO});
    directed_rows.push_back('{make_job(8'h00, KIND_ONCE, 16'd0, 16'd0), 1'b1, R_OK});
    directed_rows.push_back('{make_job(8'hFF, KIND_PERMANENT, 16'hFFFF, 16'hFFFF), 1'b1, R_OK});
    directed_rows.push_back('{make_job(8'hA5, 2'd3, 16'd0, 16'h0000), 1'b1, R_OK});
    directed_rows.push_back('{make_job(8'h5A, KIND_COUNTED, 16'd0, 16'd2), 1'b1, R_OK});
    directed_rows.push_back('{tick_word(), 1'b0, R_NONE});   // all zero-interval jobs due
    directed_rows.push_back('{tick_word(), 1'b0, R_NONE});
    directed_rows.push_back('{tick_word(), 1'b0, R_NONE});
    directed_rows.push_back('{tick_word(), 1'b0, R_NONE});   // quiet tick
    // fill the table with counted jobs that drain on later ticks
    for (int i = 0; i < 15; i++)
      directed_rows.push_back('{make_job(8'(i + 16), KIND_COUNTED, 16'd0, 16'(i + 1)),
                                1'b1, R_OK});
    directed_rows.push_back('{make_job(8'h77, KIND_ONCE, 16'd0, 16'd1), 1'b1, R_FULL});
    foreach (directed_rows[k]) begin
      send_word(directed_rows[k].w);
      if (directed_rows[k].has_fixed) begin
        got_r = pending_results[$];
        if (got_r !== directed_rows[k].fixed) begin
          $display("%0t: directed row %0d exp %h act %h", $time, k,
                   directed_rows[k].fixed, got_r);
          errors++;
        end
      end
    end

    // unit 0: a job fires on the tick after it is scheduled
    set_unit(16'd0);
    for (int i = 0; i < 6; i++) send_word(tick_word());

    // random phases across unit settings; first phase without idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_unit(16'd0);
        1: set_unit(16'd1);
        2: set_unit(16'd3);
        3: set_unit(16'hFFFF);
        4: set_unit(16'd2);
        default: set_unit(16'd1);
      endcase
      idle_on = (ph != 0);
      for (int n = 0; n < 65; n++) begin
        mode = $urandom_range(99);
        if (mode < 45) begin
          w = tick_word();
        end else begin
          w = make_job(8'($urandom), 2'($urandom_range(3)),
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4)),
                       ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(3)));
        end
        send_word(w);
      end
    end
    // flush some long-running jobs
    for (int n = 0; n < 10; n++) send_word(tick_word());

    idle_on = 1'b0;
    drain_wait();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
